FILE: rtl/core/ptsb_pkg.sv
// Package for the parallel-to-SPI transfer bridge: event codes, phase
// encoding, result record and default sizes. No dependencies.
package ptsb_pkg;

  localparam int COUNT_BITS_DEF = 13;

  localparam logic [7:0] SPI_FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_HOST     = 2'd0,
    MODE_SPI_DONE = 2'd1,
    MODE_CARD     = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LONG_LOW = 3'd1,
    PH_RD_SPI   = 3'd2,
    PH_RD_HOST  = 3'd3,
    PH_RD_FINAL = 3'd4,
    PH_WR_HOST  = 3'd5,
    PH_WR_SPI   = 3'd6
  } phase_t;

  typedef struct packed {
    logic       spi_start;
    logic [7:0] spi_tx_byte;
    logic       lines_driven;
    logic [7:0] lines_value;
    logic       busy;
    logic       spi_fast;
    logic       card_ack;
  } result_t;

endpackage

FILE: rtl/core/ptsb_ctrl.sv
// Command decoder and transfer sequencer of the parallel-to-SPI bridge.
// Holds all transfer state; uses ptsb_pkg for codes and the result record.
module ptsb_ctrl import ptsb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  input  logic       card_detect_level,
  output result_t    result
);

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  long_read_r, long_read_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [7:0]            drive_val_r, drive_val_nxt;
  logic                  drive_en_r, drive_en_nxt;
  logic                  busy_r, busy_nxt;
  logic                  fast_r, fast_nxt;
  logic                  ack_r, ack_nxt;
  logic                  pend_r, pend_nxt;
  logic                  start;
  logic [7:0]            tx;
  logic [15:0]           long_high;
  mode_t                 ev;

  assign ev        = mode_t'(mode);
  assign long_high = {3'b000, data_byte[4:0], 8'h00};

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    long_read_nxt = long_read_r;
    held_nxt      = held_r;
    drive_val_nxt = drive_val_r;
    drive_en_nxt  = drive_en_r;
    busy_nxt      = busy_r;
    fast_nxt      = fast_r;
    ack_nxt       = ack_r;
    pend_nxt      = pend_r;
    start         = 1'b0;
    tx            = 8'h00;

    case (ev)
      MODE_CARD: begin
        ack_nxt = ~card_detect_level;
      end
      MODE_HOST: begin
        case (phase_r)
          PH_IDLE: begin
            if (!data_byte[7]) begin
              count_nxt = COUNT_BITS'(data_byte[5:0]);
              busy_nxt  = 1'b1;
              pend_nxt  = 1'b0;
              if (data_byte[6]) begin
                start         = 1'b1;
                tx            = SPI_FILL_BYTE;
                drive_en_nxt  = 1'b1;
                drive_val_nxt = data_byte;
                phase_nxt     = PH_RD_SPI;
              end else begin
                phase_nxt = PH_WR_HOST;
              end
            end else if (!data_byte[6]) begin
              count_nxt     = long_high[COUNT_BITS-1:0];
              long_read_nxt = data_byte[5];
              phase_nxt     = PH_LONG_LOW;
            end else if (data_byte[5:1] == 5'd0) begin
              fast_nxt = data_byte[0];
            end
          end
          PH_LONG_LOW: begin
            count_nxt = count_r | COUNT_BITS'(data_byte);
            busy_nxt  = 1'b1;
            pend_nxt  = 1'b0;
            if (long_read_r) begin
              start         = 1'b1;
              tx            = SPI_FILL_BYTE;
              drive_en_nxt  = 1'b1;
              drive_val_nxt = data_byte;
              phase_nxt     = PH_RD_SPI;
            end else begin
              phase_nxt = PH_WR_HOST;
            end
          end
          PH_RD_SPI, PH_WR_SPI: begin
            // hold one toggle while the SPI byte is in flight
            if (!pend_r) begin
              pend_nxt = 1'b1;
              if (phase_r == PH_WR_SPI) held_nxt = data_byte;
            end
          end
          PH_RD_HOST: begin
            drive_val_nxt = held_r;
            if (count_r != '0) begin
              count_nxt = count_r - COUNT_BITS'(1);
              start     = 1'b1;
              tx        = SPI_FILL_BYTE;
              phase_nxt = PH_RD_SPI;
            end else begin
              phase_nxt = PH_RD_FINAL;
            end
          end
          PH_WR_HOST: begin
            start     = 1'b1;
            tx        = data_byte;
            phase_nxt = PH_WR_SPI;
          end
          default: begin
            drive_en_nxt  = 1'b0;
            drive_val_nxt = 8'h00;
            busy_nxt      = 1'b0;
            pend_nxt      = 1'b0;
            count_nxt     = '0;
            phase_nxt     = PH_IDLE;
          end
        endcase
      end
      MODE_SPI_DONE: begin
        if (phase_r == PH_RD_SPI) begin
          held_nxt = data_byte;
          if (pend_r) begin
            // serve the held toggle with the byte just received
            pend_nxt      = 1'b0;
            drive_val_nxt = data_byte;
            if (count_r != '0) begin
              count_nxt = count_r - COUNT_BITS'(1);
              start     = 1'b1;
              tx        = SPI_FILL_BYTE;
              phase_nxt = PH_RD_SPI;
            end else begin
              phase_nxt = PH_RD_FINAL;
            end
          end else begin
            phase_nxt = PH_RD_HOST;
          end
        end else if (phase_r == PH_WR_SPI) begin
          if (count_r != '0) begin
            count_nxt = count_r - COUNT_BITS'(1);
            if (pend_r) begin
              pend_nxt = 1'b0;
              start    = 1'b1;
              tx       = held_r;
            end else begin
              phase_nxt = PH_WR_HOST;
            end
          end else begin
            drive_en_nxt  = 1'b0;
            drive_val_nxt = 8'h00;
            busy_nxt      = 1'b0;
            pend_nxt      = 1'b0;
            count_nxt     = '0;
            phase_nxt     = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    result.spi_start    = start;
    result.spi_tx_byte  = tx;
    result.lines_driven = drive_en_nxt;
    result.lines_value  = drive_en_nxt ? drive_val_nxt : 8'h00;
    result.busy         = busy_nxt;
    result.spi_fast     = fast_nxt;
    result.card_ack     = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      long_read_r <= 1'b0;
      held_r      <= 8'h00;
      drive_val_r <= 8'h00;
      drive_en_r  <= 1'b0;
      busy_r      <= 1'b0;
      fast_r      <= 1'b0;
      ack_r       <= 1'b0;
      pend_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      long_read_r <= long_read_nxt;
      held_r      <= held_nxt;
      drive_val_r <= drive_val_nxt;
      drive_en_r  <= drive_en_nxt;
      busy_r      <= busy_nxt;
      fast_r      <= fast_nxt;
      ack_r       <= ack_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

FILE: rtl/core/parallel_to_spi_transfer_bridge.sv
// The result of a transaction is registered and valid in the cycle after
// it is accepted. One transaction per cycle while the output is not stalled;
// the state registers of ptsb_ctrl are updated at each accept and the result
// register frees up in the same cycle it is taken.
// Reset (rst_n low, synchronous): phase idle, counters and flags cleared,
// slow SPI clock, no result pending.
module parallel_to_spi_transfer_bridge import ptsb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       in_card_detect_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_spi_start,
  output logic [7:0] out_spi_tx_byte,
  output logic       out_lines_driven,
  output logic [7:0] out_lines_value,
  output logic       out_busy_res,
  output logic       out_spi_fast,
  output logic       out_card_ack
);

  logic    accept;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  result_t res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  ptsb_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (accept),
    .mode             (in_mode),
    .data_byte        (in_data_byte),
    .card_detect_level(in_card_detect_level),
    .result           (res)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_spi_start    = res_r.spi_start;
  assign out_spi_tx_byte  = res_r.spi_tx_byte;
  assign out_lines_driven = res_r.lines_driven;
  assign out_lines_value  = res_r.lines_value;
  assign out_busy_res     = res_r.busy;
  assign out_spi_fast     = res_r.spi_fast;
  assign out_card_ack     = res_r.card_ack;

endmodule

FILE: rtl/core/ptsb_checker.sv
// Port-level checks for the parallel-to-SPI transfer bridge, bound to the
// top level. Uses ptsb_pkg for event codes.
module ptsb_checker import ptsb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       in_card_detect_level,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_spi_start,
  input logic [7:0] out_spi_tx_byte,
  input logic       out_lines_driven,
  input logic [7:0] out_lines_value,
  input logic       out_busy_res,
  input logic       out_card_ack
);

  // every accepted transaction yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_card_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_CARD) |=>
      (out_card_ack == !$past(in_card_detect_level)))
    else $error("card ack is not the inverted detect level");

  a_tx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_spi_start |-> (out_spi_tx_byte == 8'h00))
    else $error("tx byte nonzero without spi start");

  a_lines_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lines_driven |-> out_busy_res)
    else $error("host lines driven outside a transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lines_value))
    else $error("stalled result changed");

endmodule

bind parallel_to_spi_transfer_bridge ptsb_checker u_ptsb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_mode             (in_mode),
  .in_card_detect_level(in_card_detect_level),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_spi_start       (out_spi_start),
  .out_spi_tx_byte     (out_spi_tx_byte),
  .out_lines_driven    (out_lines_driven),
  .out_lines_value     (out_lines_value),
  .out_busy_res        (out_busy_res),
  .out_card_ack        (out_card_ack)
);
